// ===== sv/sorted_record_insert_core_macros.svh =====
// Assertion macros shared by the sorted record insert core.
// Each macro samples on the rising edge of clock; used by sric_datapath.sv.
`ifndef SORTED_RECORD_INSERT_CORE_MACROS_SVH
`define SORTED_RECORD_INSERT_CORE_MACROS_SVH

// Checked only while reset is low.
`define SRIC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define SRIC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== sv/sric_pkg.sv =====
// Shared types, constants and the title key function of the sorted record insert core.
// Used by sric_ctrl, sric_datapath and sorted_record_insert_core; depends on nothing.
package sric_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int TITLE_BYTES = 31;
   localparam int TITLE_W     = 8 * TITLE_BYTES;
   localparam int ID_W        = 16;
   localparam int YEAR_W      = 16;
   localparam int RIDX_W      = 8;
   localparam int POS_W       = 8;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int RCMP_W      = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

   localparam int REQ_DATA_W  = 272;
   localparam int RSP_USED_W  = POS_W + ID_W + YEAR_W + TITLE_W + COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_READ      = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RD_SEL_SCAN,
      RD_SEL_SHIFT,
      RD_SEL_INDEX
   } rd_sel_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [YEAR_W-1:0]  year;
      logic [TITLE_W-1:0] title;
   } record_type;

   typedef struct packed {
      logic       capture;
      logic       prep;
      logic       scan_start;
      logic       scan_next;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mask_entry;
      logic       found;
      logic       pos_end;
      logic       shift_wr;
      logic       write_new;
      logic       load_rsp;
      status_type rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic is_read;
      logic ridx_ok;
      logic full;
      logic empty;
      logic greater;
      logic scan_last;
      logic shift_last;
      logic out_free;
   } dp_status_type;

   // Zeroes every byte after the first NUL, so that a plain unsigned compare of
   // two keys gives the byte-wise string order.
   function automatic logic [TITLE_W-1:0] title_key(input logic [TITLE_W-1:0] title);
      logic [TITLE_BYTES-1:0] zero;
      logic [TITLE_W-1:0]     key;
      for (int i = 0; i < TITLE_BYTES; i++) begin
         zero[i] = (title[TITLE_W-1-8*i -: 8] == 8'd0);
      end
      for (int i = 0; i < TITLE_BYTES; i++) begin
         if ((zero & ((TITLE_BYTES'(1) << i) - TITLE_BYTES'(1))) == '0) begin
            key[TITLE_W-1-8*i -: 8] = title[TITLE_W-1-8*i -: 8];
         end else begin
            key[TITLE_W-1-8*i -: 8] = 8'd0;
         end
      end
      return key;
   endfunction

endpackage

// ===== sv/sric_ctrl.sv =====
// Controller state machine of the sorted record insert core.
// Drives the datapath through sric_pkg::dp_cmd_type; depends on sric_pkg.
module sric_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sric_pkg::dp_status_type status,
   output sric_pkg::dp_cmd_type    cmd
);
   import sric_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_MASK,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE_NEW,
      S_READ_RD,
      S_RESPOND
   } state_type;

   state_type  state_ff, state_in;
   status_type rsp_status_ff, rsp_status_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      rsp_status_in  = rsp_status_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_SEL_SCAN;
      cmd.rsp_status = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.prep = 1'b1;
            if (status.is_read) begin
               if (status.ridx_ok) begin
                  rsp_status_in = STATUS_READ;
                  state_in      = S_READ_RD;
               end else begin
                  rsp_status_in = STATUS_BAD_INDEX;
                  state_in      = S_RESPOND;
               end
            end else if (status.full) begin
               rsp_status_in = STATUS_FULL;
               state_in      = S_RESPOND;
            end else if (status.empty) begin
               cmd.pos_end = 1'b1;
               state_in    = S_WRITE_NEW;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_SEL_SCAN;
            state_in   = S_SCAN_MASK;
         end
         S_SCAN_MASK: begin
            cmd.mask_entry = 1'b1;
            state_in       = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            // The first entry that sorts after the new record marks its slot.
            if (status.greater) begin
               cmd.found = 1'b1;
               state_in  = S_SHIFT_RD;
            end else if (status.scan_last) begin
               cmd.pos_end = 1'b1;
               state_in    = S_WRITE_NEW;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_SEL_SHIFT;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = status.shift_last ? S_WRITE_NEW : S_SHIFT_RD;
         end
         S_WRITE_NEW: begin
            cmd.write_new = 1'b1;
            rsp_status_in = STATUS_INSERTED;
            state_in      = S_RESPOND;
         end
         S_READ_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_SEL_INDEX;
            state_in   = S_RESPOND;
         end
         S_RESPOND: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== sv/sric_datapath.sv =====
// Datapath of the sorted record insert core: request registers, record memory,
// scan and shift counters, key compare and the response register. Depends on sric_pkg.
`include "sorted_record_insert_core_macros.svh"

module sric_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   input  logic                              req_cmd,
   input  logic [sric_pkg::REQ_DATA_W-1:0]   req_data,
   input  sric_pkg::dp_cmd_type              cmd,
   output sric_pkg::dp_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sric_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic [sric_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sric_pkg::*;

   logic               sort_by_title_ff;
   cmd_type            req_cmd_ff;
   logic [YEAR_W-1:0]  req_year_ff;
   logic [TITLE_W-1:0] req_title_ff;
   logic [RIDX_W-1:0]  req_ridx_ff;
   logic [TITLE_W-1:0] new_key_ff;
   logic [TITLE_W-1:0] entry_key_ff;
   logic [YEAR_W-1:0]  entry_year_ff;
   logic [IDX_W-1:0]   scan_idx_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic [IDX_W-1:0]   sh_idx_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [ID_W-1:0]    next_id_ff;
   record_type         rd_data_ff;
   record_type         mem [TABLE_DEPTH];

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   record_type         wr_data;
   logic               mem_we;

   logic [POS_W-1:0]   o_position;
   logic [ID_W-1:0]    o_id;
   logic [YEAR_W-1:0]  o_year;
   logic [TITLE_W-1:0] o_title;
   logic [COUNT_W-1:0] o_count;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sort_by_title_ff <= 1'b0;
      end else if (csr_wr_en) begin
         sort_by_title_ff <= csr_wr_data;
      end
   end

   // Request capture and key preparation.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff   <= cmd_type'(req_cmd);
         req_year_ff  <= req_data[15:0];
         req_title_ff <= {req_data[79:16], req_data[143:80], req_data[207:144],
                          req_data[263:208]};
         req_ridx_ff  <= req_data[271:264];
      end
      if (cmd.prep) begin
         new_key_ff <= title_key(req_title_ff);
      end
      if (cmd.mask_entry) begin
         entry_key_ff  <= title_key(rd_data_ff.title);
         entry_year_ff <= rd_data_ff.year;
      end
   end

   // Scan, slot and shift counters.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_next) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
      if (cmd.found) begin
         pos_ff    <= scan_idx_ff;
         sh_idx_ff <= IDX_W'(fill_ff);
      end else begin
         if (cmd.pos_end) begin
            pos_ff <= IDX_W'(fill_ff);
         end
         if (cmd.shift_wr) begin
            sh_idx_ff <= sh_idx_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         next_id_ff <= '0;
      end else if (cmd.load_rsp && cmd.rsp_status == STATUS_INSERTED) begin
         fill_ff    <= fill_ff + CNT_W'(1);
         next_id_ff <= next_id_ff + ID_W'(1);
      end
   end

   // Record memory: one read port, one write port.
   always_comb begin
      case (cmd.rd_sel)
         RD_SEL_SCAN:  rd_addr = scan_idx_ff;
         RD_SEL_SHIFT: rd_addr = sh_idx_ff - IDX_W'(1);
         RD_SEL_INDEX: rd_addr = IDX_W'(req_ridx_ff);
         default:      rd_addr = scan_idx_ff;
      endcase
      mem_we = cmd.shift_wr || cmd.write_new;
      if (cmd.shift_wr) begin
         wr_addr = sh_idx_ff;
         wr_data = rd_data_ff;
      end else begin
         wr_addr       = pos_ff;
         wr_data.id    = next_id_ff;
         wr_data.year  = req_year_ff;
         wr_data.title = req_title_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Status towards the controller.
   always_comb begin
      status.is_read    = (req_cmd_ff == CMD_READ);
      status.ridx_ok    = RCMP_W'(req_ridx_ff) < RCMP_W'(fill_ff);
      status.full       = (fill_ff == CNT_W'(TABLE_DEPTH));
      status.empty      = (fill_ff == '0);
      status.greater    = sort_by_title_ff ? (entry_key_ff > new_key_ff)
                                           : (entry_year_ff > req_year_ff);
      status.scan_last  = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == fill_ff);
      status.shift_last = ((sh_idx_ff - IDX_W'(1)) == pos_ff);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // Response fields.
   always_comb begin
      o_position = '0;
      o_id       = '0;
      o_year     = '0;
      o_title    = '0;
      o_count    = COUNT_W'(fill_ff);
      case (cmd.rsp_status)
         STATUS_INSERTED: begin
            o_position = POS_W'(pos_ff);
            o_id       = next_id_ff;
            o_year     = req_year_ff;
            o_title    = req_title_ff;
            o_count    = COUNT_W'(fill_ff + CNT_W'(1));
         end
         STATUS_READ: begin
            o_position = POS_W'(req_ridx_ff);
            o_id       = rd_data_ff.id;
            o_year     = rd_data_ff.year;
            o_title    = rd_data_ff.title;
         end
         STATUS_BAD_INDEX: begin
            o_position = POS_W'(req_ridx_ff);
         end
         default: begin
            o_position = '0;
         end
      endcase
      rsp_data_in = {{RSP_PAD_W{1'b0}}, o_count,
                     o_title[55:0], o_title[119:56], o_title[183:120], o_title[247:184],
                     o_year, o_id, o_position};
   end

   // Output register: holds one finished request while the next one is taken in.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SRIC_ASSERT(a_fill_bound, fill_ff <= CNT_W'(TABLE_DEPTH), "fill count above table depth")
   `SRIC_ASSERT(a_fill_step,
      !$stable(fill_ff) |-> (fill_ff == $past(fill_ff) + CNT_W'(1)),
      "fill count moved by more than one")
   `SRIC_ASSERT(a_rsp_slot,
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready),
      "response loaded over an unread one")
   `SRIC_ASSERT(a_shift_range,
      cmd.shift_wr |-> (sh_idx_ff > pos_ff),
      "shift write at or below the insert slot")
   `SRIC_ASSERT_ALWAYS(a_reset_empty,
      reset |=> (fill_ff == '0 && !rsp_valid_ff),
      "table not empty after reset")

endmodule

// ===== sv/sorted_record_insert_core.sv =====
// Insert: entries are read, masked and compared from the front until one sorts after the new
// record or the last is passed; entries from that slot on move up one place, last first, then
// the record is written. Read: one memory read; full table or bad index: no memory access.
// One request at a time; the next is taken while the previous response waits in the output register.
// Synchronous reset empties the table, zeroes the ID counter and selects year order; no clearing pass.
module sorted_record_insert_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,  // sort_by_title
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,    // cmd
   input  logic [271:0] req_tdata,    // year, title_w0, title_w1, title_w2, title_w3, read_index
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,    // status
   output logic [303:0] rsp_tdata     // position, entry_id, entry_year, entry_title_w0,
                                      // entry_title_w1, entry_title_w2, entry_title_w3,
                                      // entry_count, zero padding
);
   import sric_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   sric_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   sric_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_cmd     (req_tuser),
      .req_data    (req_tdata),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== sim/sorted_record_insert_core_tb.sv =====
// Self-checking testbench for sorted_record_insert_core: random and directed inserts and reads
// in both sort orders, checked against an in-bench model of the ordered record table.
// Depends on sric_pkg and the sorted_record_insert_core RTL only.
module sorted_record_insert_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sric_pkg::*;

   typedef struct {
      cmd_type            cmd;
      logic [15:0]        year;
      logic [TITLE_W-1:0] title;
      logic [7:0]         read_index;
   } catalog_request_type;

   typedef struct {
      status_type         status;
      logic [7:0]         position;
      logic [15:0]        id;
      logic [15:0]        year;
      logic [TITLE_W-1:0] title;
      logic [8:0]         count;
   } catalog_reply_type;

   typedef struct {
      logic [15:0]        year;
      logic [TITLE_W-1:0] title;
      logic [15:0]        id;
   } shelf_entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;
   logic [271:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;
   logic [303:0] rsp_tdata;

   sorted_record_insert_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Model of the table as the block should hold it.
   shelf_entry_type shelf [TABLE_DEPTH];
   int         shelf_fill = 0;
   logic [15:0] id_counter = '0;
   bit         title_order = 1'b0;

   catalog_request_type pending_requests [$];
   catalog_reply_type   awaited_replies [$];
   logic [TITLE_W-1:0] title_pool [$];
   int planned_fill = 0;

   int mismatches = 0;
   int n_stored = 0;
   int n_refused = 0;
   int n_read = 0;
   int n_bad_index = 0;
   int n_order_writes = 0;

   function automatic logic [271:0] pack_request(catalog_request_type r);
      return {r.read_index, r.title[55:0], r.title[119:56], r.title[183:120],
              r.title[247:184], r.year};
   endfunction

   // Byte-wise string order; nothing after the first NUL takes part.
   function automatic bit title_ranks_after(logic [TITLE_W-1:0] a, logic [TITLE_W-1:0] b);
      logic [7:0] x;
      logic [7:0] y;
      for (int i = 0; i < TITLE_BYTES; i++) begin
         x = a[TITLE_W-1-8*i -: 8];
         y = b[TITLE_W-1-8*i -: 8];
         if (x != y) return x > y;
         if (x == 8'd0) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic void apply_request(catalog_request_type r);
      catalog_reply_type reply;
      int slot;
      reply = '{status: STATUS_INSERTED, position: '0, id: '0, year: '0, title: '0, count: '0};
      if (r.cmd == CMD_INSERT) begin
         if (shelf_fill >= TABLE_DEPTH) begin
            reply.status = STATUS_FULL;
            n_refused++;
         end else begin
            slot = shelf_fill;
            for (int i = 0; i < shelf_fill; i++) begin
               if (title_order ? title_ranks_after(shelf[i].title, r.title)
                               : (shelf[i].year > r.year)) begin
                  slot = i;
                  break;
               end
            end
            for (int i = shelf_fill; i > slot; i--) shelf[i] = shelf[i-1];
            shelf[slot] = '{year: r.year, title: r.title, id: id_counter};
            shelf_fill++;
            reply.position = slot[7:0];
            reply.id = id_counter;
            reply.year = r.year;
            reply.title = r.title;
            id_counter = id_counter + 16'd1;
            n_stored++;
         end
      end else begin
         reply.position = r.read_index;
         if (r.read_index < shelf_fill) begin
            reply.status = STATUS_READ;
            reply.id = shelf[r.read_index].id;
            reply.year = shelf[r.read_index].year;
            reply.title = shelf[r.read_index].title;
            n_read++;
         end else begin
            reply.status = STATUS_BAD_INDEX;
            n_bad_index++;
         end
      end
      reply.count = shelf_fill[8:0];
      awaited_replies.push_back(reply);
   endfunction

   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      end
   endfunction

   // Request driver.
   int accepted_requests = 0;
   catalog_request_type on_offer;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(on_offer);
            accepted_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 &&
                ((accepted_requests > 700 && accepted_requests < 1000) ||
                 $urandom_range(99) >= 7)) begin
               on_offer = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= on_offer.cmd;
               req_tdata <= pack_request(on_offer);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with two long hold-offs so that the block backs up.
   int taken_replies = 0;
   int hold_left = 0;
   int hold_mark = 200;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) taken_replies++;
         if (hold_left == 0 && taken_replies >= hold_mark) begin
            hold_left = 500;
            hold_mark = hold_mark + 1500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (taken_replies > 700 && taken_replies < 1000) ||
                          ($urandom_range(99) >= 7);
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      catalog_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with none outstanding, status %0d", $realtime, rsp_tuser);
         end else begin
            want = awaited_replies.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_tuser));
            check_field("position", 64'(want.position), 64'(rsp_tdata[7:0]));
            check_field("entry_id", 64'(want.id), 64'(rsp_tdata[23:8]));
            check_field("entry_year", 64'(want.year), 64'(rsp_tdata[39:24]));
            check_field("entry_title_w0", want.title[247:184], rsp_tdata[103:40]);
            check_field("entry_title_w1", want.title[183:120], rsp_tdata[167:104]);
            check_field("entry_title_w2", want.title[119:56], rsp_tdata[231:168]);
            check_field("entry_title_w3", 64'(want.title[55:0]), 64'(rsp_tdata[287:232]));
            check_field("entry_count", 64'(want.count), 64'(rsp_tdata[296:288]));
         end
      end
   end

   function automatic logic [TITLE_W-1:0] str_title(string s);
      logic [TITLE_W-1:0] t;
      t = '0;
      for (int i = 0; i < s.len(); i++) t[TITLE_W-1-8*i -: 8] = s[i];
      return t;
   endfunction

   // Titles from a narrow alphabet give ties and shared prefixes; some carry
   // junk after the terminating NUL.
   function automatic logic [TITLE_W-1:0] rand_title();
      logic [TITLE_W-1:0] t;
      int  len;
      bit  narrow;
      if (title_pool.size() > 0 && $urandom_range(99) < 15)
         return title_pool[$urandom_range(title_pool.size() - 1)];
      t = '0;
      len = $urandom_range(31);
      narrow = $urandom_range(1);
      for (int i = 0; i < len; i++)
         t[TITLE_W-1-8*i -: 8] = narrow ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 30)
         for (int i = len + 1; i < TITLE_BYTES; i++) t[TITLE_W-1-8*i -: 8] = 8'($urandom_range(255));
      title_pool.push_back(t);
      if (title_pool.size() > 64) void'(title_pool.pop_front());
      return t;
   endfunction

   function automatic logic [15:0] rand_year();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3, 4, 5, 6: return 16'(1990 + $urandom_range(5));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic void queue_request(cmd_type c, logic [15:0] y, logic [TITLE_W-1:0] t,
                                         logic [7:0] ix);
      pending_requests.push_back('{cmd: c, year: y, title: t, read_index: ix});
      if (c == CMD_INSERT && planned_fill < TABLE_DEPTH) planned_fill++;
   endfunction

   function automatic void queue_random(int n, int insert_pct);
      int  pick;
      logic [7:0] ix;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (planned_fill > 0 && pick < 70)
            ix = 8'($urandom_range(planned_fill - 1));
         else if (pick < 80)
            ix = 8'(planned_fill);
         else
            ix = 8'($urandom_range(255));
         queue_request(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_READ,
                       rand_year(), rand_title(), ix);
      end
   endfunction

   // Sampled on the falling edge, so that every handshake of the rising edge has settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || awaited_replies.size() != 0);
   endtask

   task automatic set_order(bit want_title);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= want_title;
      title_order = want_title;
      n_order_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [TITLE_W-1:0] t;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Year order: empty table reads, extreme years, equal years keep arrival order.
      set_order(1'b0);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd0);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'hFF);
      queue_request(CMD_INSERT, 16'd2000, str_title("middle"), 8'hFF);
      queue_request(CMD_INSERT, 16'd0, str_title("zzz"), 8'd0);
      queue_request(CMD_INSERT, 16'hFFFF, '1, 8'd3);
      t = str_title("b");
      t[TITLE_W-1-8*4 -: 8] = 8'hA5;
      queue_request(CMD_INSERT, 16'd2000, t, 8'd0);
      queue_request(CMD_INSERT, 16'd2000, str_title("a"), 8'd0);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd0);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd2);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd4);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd5);
      wait_idle();

      // Title order over entries placed by year: empty and maximal titles, prefixes,
      // ties differing only after the NUL, and a difference in the last byte.
      set_order(1'b1);
      queue_request(CMD_INSERT, 16'd7, '0, 8'd0);
      queue_request(CMD_INSERT, 16'd8, '1, 8'd0);
      queue_request(CMD_INSERT, 16'd9, str_title("ab"), 8'd0);
      queue_request(CMD_INSERT, 16'd10, str_title("abc"), 8'd0);
      t = str_title("ab");
      t[TITLE_W-1-8*5 -: 8] = 8'h5A;
      queue_request(CMD_INSERT, 16'd11, t, 8'd0);
      t = '1;
      t[7:0] = 8'hFE;
      queue_request(CMD_INSERT, 16'd12, t, 8'd0);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd0);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd10);
      queue_request(CMD_READ, rand_year(), rand_title(), 8'd11);
      wait_idle();

      // Mostly reads while the table grows slowly, switching order each phase.
      for (int ph = 0; ph < 9; ph++) begin
         set_order(ph[0]);
         queue_random(170, 15);
         wait_idle();
      end

      // Fill the table, then keep pressing on it once full.
      set_order($urandom_range(1));
      queue_random(120, 70);
      wait_idle();
      set_order(1'b0);
      queue_random(230, 30);
      wait_idle();
      repeat (50) @(posedge clock);

      if (awaited_replies.size() != 0) begin
         mismatches++;
         $display("%0d responses never arrived", awaited_replies.size());
      end
      $display("Stored %0d records, refused %0d on a full table, %0d reads in range and %0d",
               n_stored, n_refused, n_read, n_bad_index);
      $display("out of range, across %0d sort order writes; %0d mismatches.",
               n_order_writes, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #32_000_000;
      $display("Timed out with %0d responses outstanding", awaited_replies.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
